FILE: rtl/ssti_pkg.sv
package ssti_pkg;

   typedef enum logic [1:0] {
      OP_P2N = 2'd0,
      OP_N2P = 2'd1,
      OP_NBP = 2'd2,
      OP_NBN = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_CONV,
      ST_TILE,
      ST_MUL,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic sqrt_step;
      logic conv;
      logic tile_first;
      logic tile_next;
      logic mul;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sqrt_done;
      logic tile_last;
   } sts_type;

   // one bit pair per step, from 2^30 down to 2^0
   localparam int SQRT_STEPS = 16;

endpackage

FILE: rtl/square_spiral_tile_indexer.sv
// Square-spiral tile indexer.
// Request channel (req_*): operation, x/z coordinates and tile number; one
// beat taken when req_valid and req_ready are high. Result channel (rsp_*):
// one beat per result tile, last_of_run high on the final beat of a request.
// csr_write_enable loads the neighbourhood radius (reset value 1); write it
// only while the block is idle.
// Point to number: the request beat is followed by a tile step, a squaring
// step and the result beat. Number to point: 16 square root iterations, a
// conversion step and the result beat. Neighbourhoods: a tile step, a
// squaring step and a result beat per listed tile (up to 61 tiles at radius
// 5), after the root and conversion steps when the centre is given by
// number; one tile a beat. One request is worked at a time; req_ready is
// high only when idle, which the block reaches in the cycle after the final
// beat is taken. The square root unit works one bit pair per cycle, and each
// tile is squared in its own stage. A stalled result beat holds until
// rsp_ready.
// Synchronous reset returns the controller to idle and the radius to 1.
module square_spiral_tile_indexer #(
   parameter int MAX_RADIUS  = 5,
   parameter int COORD_LIMIT = 16384
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic signed [15:0] req_x_coord,
   input  logic signed [15:0] req_z_coord,
   input  logic [30:0]        req_tile_number,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [30:0]        rsp_result_number,
   output logic signed [15:0] rsp_result_x,
   output logic signed [15:0] rsp_result_z,
   output logic               rsp_range_error,
   output logic               rsp_last_of_run,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_write_data
);

   logic [2:0] radius_ff;
   always_ff @(posedge clock) begin
      if (reset) radius_ff <= 3'd1;
      else if (csr_write_enable) radius_ff <= csr_write_data;
   end

   ssti_pkg::cmd_type cmd;
   ssti_pkg::sts_type sts;

   ssti_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_operation,
      .rsp_valid, .rsp_ready, .cmd, .sts
   );

   ssti_datapath #(.MAX_RADIUS(MAX_RADIUS), .COORD_LIMIT(COORD_LIMIT)) u_dp (
      .clock, .cmd, .sts, .radius(radius_ff), .req_operation, .req_x_coord,
      .req_z_coord, .req_tile_number, .rsp_result_number, .rsp_result_x,
      .rsp_result_z, .rsp_range_error, .rsp_last_of_run
   );

endmodule

FILE: rtl/ssti_datapath.sv
module ssti_datapath #(
   parameter int MAX_RADIUS  = 5,
   parameter int COORD_LIMIT = 16384
) (
   input  logic                clock,
   input  ssti_pkg::cmd_type   cmd,
   output ssti_pkg::sts_type   sts,
   input  logic [2:0]          radius,
   input  logic [1:0]          req_operation,
   input  logic signed [15:0]  req_x_coord,
   input  logic signed [15:0]  req_z_coord,
   input  logic [30:0]         req_tile_number,
   output logic [30:0]         rsp_result_number,
   output logic signed [15:0]  rsp_result_x,
   output logic signed [15:0]  rsp_result_z,
   output logic                rsp_range_error,
   output logic                rsp_last_of_run
);

   // request registers
   logic [1:0]         op_ff;
   logic [30:0]        n_ff;
   logic signed [17:0] cx_ff, cz_ff;
   logic [2:0]         r_ff;
   // square root state
   logic [31:0]        rem_ff, res_ff, bit_ff, rem_in, res_in;
   logic [4:0]         cnt_ff;
   // enumeration
   logic signed [17:0] a_ff, b_ff;
   logic signed [18:0] aa_ff, bb_ff;
   logic signed [37:0] sq_ff;
   logic               err_ff, last_ff;
   logic [2:0]         zone_ff;

   logic [2:0] r_clip;
   assign r_clip = (radius > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : radius;

   // one sqrt step
   always_comb begin
      if ({1'b0, rem_ff} >= {1'b0, res_ff} + {1'b0, bit_ff}) begin
         rem_in = rem_ff - (res_ff + bit_ff);
         res_in = (res_ff >> 1) + bit_ff;
      end else begin
         rem_in = rem_ff;
         res_in = res_ff >> 1;
      end
   end

   assign sts.sqrt_done = (cnt_ff == 5'(ssti_pkg::SQRT_STEPS - 1));

   // conversion from root to point; the root of a 31-bit number fits 16 bits
   logic [15:0]        r1, r2, sq;
   logic [31:0]        lo, hi, s;
   logic signed [33:0] px, pz;
   logic signed [33:0] hh, half;
   logic signed [32:0] dn;
   always_comb begin
      r1 = res_ff[15:0];
      r2 = res_ff[15:0] + 16'd1;
      lo = 32'(r1) * 32'(r1);
      hi = 32'(r2) * 32'(r2);
      sq = r1;
      s  = lo;
      if ({1'b0, n_ff} != lo && ({1'b0, n_ff} - lo) > (hi - {1'b0, n_ff})) begin
         sq = r2;
         s  = hi;
      end
      dn   = $signed({2'b0, n_ff}) - $signed({1'b0, s});
      half = $signed({19'd0, sq[15:1]});
      hh   = half + $signed({33'd0, sq[0]});
      if (!sq[0]) begin
         if (!dn[32]) begin
            px = half;
            pz = -half + 34'(dn);
         end else begin
            px = half + 34'(dn);
            pz = -half;
         end
      end else begin
         if (!dn[32]) begin
            px = -hh;
            pz = hh - 34'sd1 - 34'(dn);
         end else begin
            px = -hh - 34'(dn);
            pz = hh - 34'sd1;
         end
      end
   end

   // tile helpers
   logic signed [17:0] d, w;
   always_comb begin
      d = b_ff - cz_ff;
      if (d < 0) d = -d;
      w = $signed({15'd0, r_ff}) - d;
   end
   assign sts.tile_last = (b_ff == cz_ff - $signed({15'd0, r_ff}))
                        && (a_ff == cx_ff + w);

   logic signed [17:0] lim;
   assign lim = 18'(COORD_LIMIT);

   logic signed [17:0] ta, tb;
   logic signed [17:0] tw;
   always_comb begin
      tw = '0;
      if (cmd.tile_first) begin
         tb = cz_ff + $signed({15'd0, r_ff});
         ta = cx_ff;
      end else if (a_ff == cx_ff + w) begin
         tb = b_ff - 18'sd1;
         tw = b_ff - 18'sd1 - cz_ff;
         if (tw < 0) tw = -tw;
         ta = cx_ff - ($signed({15'd0, r_ff}) - tw);
      end else begin
         tb = b_ff;
         ta = a_ff + 18'sd1;
      end
   end

   logic signed [18:0] mul_a;
   logic [2:0]         zone;
   logic [15:0]        mag;
   logic [31:0]        mag_sq;
   always_comb begin
      zone  = 3'd4;
      mul_a = aa_ff;
      if (bb_ff > 0 && aa_ff >= -bb_ff && aa_ff < bb_ff) begin
         zone = 3'd0; mul_a = bb_ff;
      end else if (aa_ff < 0 && bb_ff < -aa_ff && bb_ff >= aa_ff) begin
         zone = 3'd1; mul_a = aa_ff;
      end else if (bb_ff < 0 && aa_ff <= -bb_ff && aa_ff > bb_ff) begin
         zone = 3'd2; mul_a = bb_ff;
      end else if (aa_ff > 0 && bb_ff <= aa_ff && bb_ff > -aa_ff) begin
         zone = 3'd3; mul_a = aa_ff;
      end
      // square through the magnitude, which fits 16 bits
      mag    = 16'((mul_a < 0) ? -mul_a : mul_a);
      mag_sq = 32'(mag) * 32'(mag);
   end

   logic signed [37:0] num;
   always_comb begin
      case (zone_ff)
         3'd0: num = 4 * sq_ff + 3 * 38'(bb_ff) - 38'(aa_ff);
         3'd1: num = 4 * sq_ff + 3 * 38'(aa_ff) - 38'(bb_ff);
         3'd2: num = 4 * sq_ff + 38'(bb_ff) + 38'(aa_ff);
         3'd3: num = 4 * sq_ff + 38'(aa_ff) + 38'(bb_ff);
         default: num = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation;
         n_ff  <= req_tile_number;
         cx_ff <= 18'(req_x_coord);
         cz_ff <= 18'(req_z_coord);
         r_ff  <= (req_operation inside {ssti_pkg::OP_NBP, ssti_pkg::OP_NBN})
                  ? r_clip : 3'd0;
         rem_ff <= {1'b0, req_tile_number};
         res_ff <= '0;
         bit_ff <= 32'h4000_0000;
         cnt_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
         bit_ff <= bit_ff >> 2;
         cnt_ff <= cnt_ff + 5'd1;
      end
      if (cmd.conv) begin
         aa_ff <= 19'(px);
         bb_ff <= 19'(pz);
         cx_ff <= 18'(px);
         cz_ff <= 18'(pz);
         err_ff <= (px > 34'(COORD_LIMIT)) || (px < -34'(COORD_LIMIT))
                || (pz > 34'(COORD_LIMIT)) || (pz < -34'(COORD_LIMIT));
      end
      if (cmd.tile_first || cmd.tile_next) begin
         a_ff  <= ta;
         b_ff  <= tb;
         aa_ff <= 19'(ta);
         bb_ff <= 19'(tb);
         err_ff <= (ta > lim) || (ta < -lim) || (tb > lim) || (tb < -lim);
      end
      if (cmd.mul) begin
         sq_ff   <= {6'd0, mag_sq};
         zone_ff <= zone;
         last_ff <= sts.tile_last;
      end
   end

   // result is zero on a range error; number-to-point echoes n; others use zone formula
   assign rsp_result_number = err_ff ? 31'd0 :
                              (op_ff == ssti_pkg::OP_N2P) ? n_ff : num[30:0];
   assign rsp_result_x    = aa_ff[15:0];
   assign rsp_result_z    = bb_ff[15:0];
   assign rsp_range_error = err_ff;
   assign rsp_last_of_run = (op_ff == ssti_pkg::OP_N2P) ? 1'b1 : last_ff;

endmodule

FILE: rtl/ssti_ctrl.sv
module ssti_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ssti_pkg::cmd_type  cmd,
   input  ssti_pkg::sts_type  sts
);

   ssti_pkg::state_type state_ff, state_in;
   logic [1:0] op_ff;
   logic       tile_flag;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssti_pkg::ST_IDLE:
            if (req_valid) begin
               if (req_operation inside {ssti_pkg::OP_P2N, ssti_pkg::OP_NBP})
                  state_in = ssti_pkg::ST_TILE;
               else
                  state_in = ssti_pkg::ST_SQRT;
            end
         ssti_pkg::ST_SQRT:
            if (sts.sqrt_done) state_in = ssti_pkg::ST_CONV;
         ssti_pkg::ST_CONV:
            state_in = (op_ff == ssti_pkg::OP_N2P) ? ssti_pkg::ST_OUT : ssti_pkg::ST_TILE;
         ssti_pkg::ST_TILE: state_in = ssti_pkg::ST_MUL;
         ssti_pkg::ST_MUL:  state_in = ssti_pkg::ST_OUT;
         ssti_pkg::ST_OUT:
            if (rsp_ready) state_in = tile_flag ? ssti_pkg::ST_IDLE : ssti_pkg::ST_TILE;
         default: state_in = ssti_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ssti_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ssti_pkg::ST_SQRT: cmd.sqrt_step = 1'b1;
         ssti_pkg::ST_CONV: cmd.conv = 1'b1;
         ssti_pkg::ST_TILE: begin
            cmd.tile_first = !tile_flag;
            cmd.tile_next  = tile_flag;
         end
         ssti_pkg::ST_MUL: cmd.mul = 1'b1;
         ssti_pkg::ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   // tile_flag: in TILE, first tile already stepped; in OUT, final beat of the run
   logic first_done_ff, fin_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssti_pkg::ST_IDLE;
         op_ff <= ssti_pkg::OP_P2N;
         first_done_ff <= 1'b0;
         fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load) begin
            op_ff <= req_operation;
            first_done_ff <= 1'b0;
            fin_ff <= 1'b0;
         end
         if (cmd.tile_first || cmd.tile_next) first_done_ff <= 1'b1;
         if (cmd.mul) fin_ff <= sts.tile_last;
         if (state_ff == ssti_pkg::ST_CONV && op_ff == ssti_pkg::OP_N2P) fin_ff <= 1'b1;
      end
   end
   assign tile_flag = (state_ff == ssti_pkg::ST_OUT) ? fin_ff : first_done_ff;

   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result shown");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff != ssti_pkg::ST_IDLE) else $error("load without leaving idle");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");

endmodule

FILE: bench/square_spiral_tile_indexer_tb.sv
module square_spiral_tile_indexer_tb;

   localparam int  LIM        = 16384;
   localparam int  MAX_R      = 5;
   localparam int  CYCLE_CAP  = 3000000;

   typedef struct packed {
      logic [30:0] number;
      logic [15:0] x;
      logic [15:0] z;
      logic        err;
      logic        last;
   } tile_beat_type;

   typedef struct {
      ssti_pkg::op_type op;
      logic [15:0]      x;
      logic [15:0]      z;
      logic [30:0]      n;
      bit               typed;
      tile_beat_type    want;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_operation;
   logic signed [15:0] req_x_coord;
   logic signed [15:0] req_z_coord;
   logic [30:0]       req_tile_number;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [30:0]       rsp_result_number;
   logic signed [15:0] rsp_result_x;
   logic signed [15:0] rsp_result_z;
   logic              rsp_range_error;
   logic              rsp_last_of_run;
   logic              csr_write_enable;
   logic [2:0]        csr_write_data;

   tile_beat_type pending_tiles[$];
   logic [2:0]    radius_reg;
   int            errors;
   int            cycles;
   bit            no_gaps;
   bit            long_hold;

   square_spiral_tile_indexer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_x_coord       (req_x_coord),
      .req_z_coord       (req_z_coord),
      .req_tile_number   (req_tile_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_number (rsp_result_number),
      .rsp_result_x      (rsp_result_x),
      .rsp_result_z      (rsp_result_z),
      .rsp_range_error   (rsp_range_error),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // append one expected beat
   function automatic void queue_beat(tile_beat_type t);
      pending_tiles = {pending_tiles, t};
   endfunction

   // bitwise integer square root, one bit pair per pass
   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bit_v;
      res = 0;
      bit_v = 64'h1_0000_0000;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   // spiral number of a tile, by zone
   function automatic longint spiral_number(longint a, longint b);
      if (b > 0 && a >= -b && a < b) return 4*b*b + 3*b - a;
      if (a < 0 && b < -a && b >= a) return 4*a*a + 3*a - b;
      if (b < 0 && a <= -b && a > b) return 4*b*b + b + a;
      if (a > 0 && b <= a && b > -a) return 4*a*a + a + b;
      return 0;
   endfunction

   // tile of a spiral number via the nearest perfect square
   task automatic spiral_tile(input longint n, output longint px, output longint pz);
      longint r, lo, hi, sq, s, h;
      r  = longint'(isqrt(longint'(n)));
      lo = r * r;
      hi = (r + 1) * (r + 1);
      sq = r;
      s  = lo;
      if (n != lo && n - lo > hi - n) begin
         sq = r + 1;
         s  = hi;
      end
      if (sq[0] == 1'b0) begin
         if (n >= s) begin
            px = sq / 2;
            pz = -(sq / 2) + n - s;
         end else begin
            px = sq / 2 - s + n;
            pz = -(sq / 2);
         end
      end else begin
         h = (sq + 1) / 2;
         if (n >= s) begin
            px = -h;
            pz = h - 1 - n + s;
         end else begin
            px = -h + s - n;
            pz = h - 1;
         end
      end
   endtask

   function automatic bit off_grid(longint a, longint b);
      return a < -LIM || a > LIM || b < -LIM || b > LIM;
   endfunction

   function automatic tile_beat_type make_beat(longint num, longint a, longint b,
                                               bit err, bit last);
      tile_beat_type t;
      t.number = err ? 31'd0 : num[30:0];
      t.x      = a[15:0];
      t.z      = b[15:0];
      t.err    = err;
      t.last   = last;
      return t;
   endfunction

   // expected beats for one accepted request
   task automatic predict_tiles(ssti_pkg::op_type op, logic [15:0] x, logic [15:0] z,
                                logic [30:0] n);
      longint cx, cz, r, a, b, d, w, px, pz;
      bit     err;
      cx = longint'($signed(x));
      cz = longint'($signed(z));
      r  = (radius_reg > MAX_R) ? MAX_R : radius_reg;
      case (op)
         ssti_pkg::OP_P2N: begin
            err = off_grid(cx, cz);
            queue_beat(make_beat(spiral_number(cx, cz), cx, cz, err, 1'b1));
         end
         ssti_pkg::OP_N2P: begin
            spiral_tile(longint'(n), px, pz);
            err = off_grid(px, pz);
            queue_beat(make_beat(longint'(n), px, pz, err, 1'b1));
         end
         default: begin
            if (op == ssti_pkg::OP_NBN) spiral_tile(longint'(n), cx, cz);
            for (b = cz + r; b >= cz - r; b--) begin
               d = (b < cz) ? cz - b : b - cz;
               w = r - d;
               for (a = cx - w; a <= cx + w; a++) begin
                  err = off_grid(a, b);
                  queue_beat(make_beat(err ? 0 : spiral_number(a, b), a, b,
                     err, (b == cz - r) && (a == cx + w)));
               end
            end
         end
      endcase
   endtask

   // offer one request beat; valid is only lowered when a gap follows
   task automatic send_request(ssti_pkg::op_type op, logic [15:0] x, logic [15:0] z,
                               logic [30:0] n, bit typed, tile_beat_type want);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_x_coord     <= x;
      req_z_coord     <= z;
      req_tile_number <= n;
      do @(posedge clock); while (!req_ready);
      if (typed) queue_beat(want);
      else predict_tiles(op, x, z, n);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_tiles.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_radius(logic [2:0] r);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= r;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      radius_reg = r;
   endtask

   function automatic logic [15:0] pick_coord();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 3) return 16'($urandom);
      if (sel < 7) return 16'($signed($urandom_range(0, 80)) - 40);
      if ($urandom_range(0, 1)) return 16'(LIM - 6 + $urandom_range(0, 12));
      return 16'(-LIM - 6 + $urandom_range(0, 12));
   endfunction

   function automatic logic [30:0] pick_number();
      int          sel;
      longint      k;
      sel = $urandom_range(0, 9);
      if (sel < 3) return 31'($urandom);
      if (sel < 6) return 31'($urandom_range(0, 2000));
      k = $urandom_range(0, 32770);
      k = k * k + $urandom_range(0, 4) - 2;
      if (k < 0) k = 0;
      return k[30:0];
   endfunction

   // result beat checker
   always @(posedge clock) begin
      tile_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_tiles.size() == 0) begin
            $error("unexpected result beat: number %0d x %0d z %0d",
               rsp_result_number, rsp_result_x, rsp_result_z);
            errors++;
         end else begin
            want = pending_tiles.pop_front();
            if (rsp_result_number !== want.number) begin
               $error("result_number: expected %0d, got %0d", want.number, rsp_result_number);
               errors++;
            end
            if (rsp_result_x !== want.x) begin
               $error("result_x: expected %0d, got %0d", $signed(want.x), rsp_result_x);
               errors++;
            end
            if (rsp_result_z !== want.z) begin
               $error("result_z: expected %0d, got %0d", $signed(want.z), rsp_result_z);
               errors++;
            end
            if (rsp_range_error !== want.err) begin
               $error("range_error: expected %0d, got %0d", want.err, rsp_range_error);
               errors++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0d, got %0d", want.last, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side back-pressure, one draw per beat
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         stall = no_gaps ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      stim_row_type dir_rows[22] = '{
         '{ssti_pkg::OP_P2N, 16'd0,    16'd0,    31'd0,          1,
            '{31'd0, 16'd0, 16'd0, 1'b0, 1'b1}},
         '{ssti_pkg::OP_P2N, 16'd1,    16'd0,    31'd0,          1,
            '{31'd5, 16'd1, 16'd0, 1'b0, 1'b1}},
         '{ssti_pkg::OP_P2N, 16'd0,    16'd1,    31'd0,          1,
            '{31'd7, 16'd0, 16'd1, 1'b0, 1'b1}},
         '{ssti_pkg::OP_P2N, 16'h4000, 16'h4000, 31'd0,          0, '0},
         '{ssti_pkg::OP_P2N, 16'hC000, 16'hC000, 31'd0,          1,
            '{31'd1073709056, 16'hC000, 16'hC000, 1'b0, 1'b1}},
         '{ssti_pkg::OP_P2N, 16'h4001, 16'd0,    31'd0,          1,
            '{31'd0, 16'h4001, 16'd0, 1'b1, 1'b1}},
         '{ssti_pkg::OP_P2N, 16'h8000, 16'h7FFF, 31'd0,          1,
            '{31'd0, 16'h8000, 16'h7FFF, 1'b1, 1'b1}},
         '{ssti_pkg::OP_P2N, 16'hFFFF, 16'hFFFF, 31'd0,          0, '0},
         '{ssti_pkg::OP_N2P, 16'hFFFF, 16'h0000, 31'd0,          1,
            '{31'd0, 16'd0, 16'd0, 1'b0, 1'b1}},
         '{ssti_pkg::OP_N2P, 16'd0,    16'd0,    31'd5,          1,
            '{31'd5, 16'd1, 16'd0, 1'b0, 1'b1}},
         '{ssti_pkg::OP_N2P, 16'd0,    16'd0,    31'd7,          1,
            '{31'd7, 16'd0, 16'd1, 1'b0, 1'b1}},
         '{ssti_pkg::OP_N2P, 16'd0,    16'd0,    31'd9,          0, '0},
         '{ssti_pkg::OP_N2P, 16'd0,    16'd0,    31'h7FFFFFFF,   0, '0},
         '{ssti_pkg::OP_N2P, 16'd0,    16'd0,    31'd1073807360, 0, '0},
         '{ssti_pkg::OP_N2P, 16'd0,    16'd0,    31'd1073741824, 0, '0},
         '{ssti_pkg::OP_NBP, 16'd0,    16'd0,    31'd0,          0, '0},
         '{ssti_pkg::OP_NBP, 16'h4000, 16'd0,    31'd0,          0, '0},
         '{ssti_pkg::OP_NBP, 16'hC000, 16'h4000, 31'd0,          0, '0},
         '{ssti_pkg::OP_NBP, 16'h7FFF, 16'h8000, 31'd0,          0, '0},
         '{ssti_pkg::OP_NBN, 16'd0,    16'd0,    31'd0,          0, '0},
         '{ssti_pkg::OP_NBN, 16'd0,    16'd0,    31'd1073807360, 0, '0},
         '{ssti_pkg::OP_NBN, 16'd0,    16'd0,    31'h7FFFFFFF,   0, '0}
      };
      logic [2:0] phase_radius[9] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd7, 3'd5, 3'd6, 3'd4, 3'd1};
      int         phase_items[9]  = '{60, 60, 80, 70, 40, 40, 30, 50, 70};
      int         p;
      int         i;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = '0;
      req_x_coord      = '0;
      req_z_coord      = '0;
      req_tile_number  = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      radius_reg       = 3'd1;
      errors           = 0;
      cycles           = 0;
      no_gaps          = 1'b0;
      long_hold        = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset radius
      foreach (dir_rows[k])
         send_request(dir_rows[k].op, dir_rows[k].x, dir_rows[k].z, dir_rows[k].n,
            dir_rows[k].typed, dir_rows[k].want);

      // random phases, one radius each
      for (p = 0; p < 9; p++) begin
         set_radius(phase_radius[p]);
         no_gaps = (p == 2);
         if (p == 3) long_hold = 1'b1;
         for (i = 0; i < phase_items[p]; i++)
            send_request(ssti_pkg::op_type'($urandom_range(0, 3)), pick_coord(),
               pick_coord(), pick_number(), 1'b0, '0);
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: square_spiral_tile_indexer.f
rtl/ssti_pkg.sv
rtl/ssti_datapath.sv
rtl/ssti_ctrl.sv
rtl/square_spiral_tile_indexer.sv
bench/square_spiral_tile_indexer_tb.sv
